// File: hdl/mcr_pkg.sv
package mcr_pkg;

  // Default width of the center and radius coordinates.
  localparam int unsigned CoordBitsDef = 10;

  // Input item kinds carried on the slave tuser bit.
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_e;

  // Number of symmetric pixels that one step gives.
  localparam int unsigned PixPerStep = 8;

endpackage

// File: hdl/midpoint_circle_rasterizer_unit.sv
// Channel   Dir  tdata (low bit up)                          tuser / tlast
// s_axis    in   center_x, center_y, radius (3*C bits,      tuser: req_type
//                zero padded to whole bytes)                 (0 start, 1 step)
// m_axis    out  pixel_x, pixel_y (signed, C+2 bits each,   tuser: circle_done
//                zero padded to whole bytes)                 tlast: last_of_step
//
// A start item and a step item while idle give no results. Each is taken as
// soon as the step buffer has room, which is the same cycle when no step is
// being sent out. A step item while a circle is active gives eight pixel items,
// one per cycle while the output is not stalled; the next item is taken once
// the last pixel enters the single output register fed by the pixel sequencer.
// Reset is asynchronous and active low; it clears the circle state and the
// valid flags of the step buffer and the output register. A stalled output
// holds its item, and the input side keeps accepting as long as the step
// buffer has room.
module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // center_x, center_y, radius from the lowest bit up, then zero padding.
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // req_type.
  input  logic                                 s_axis_tuser,

  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pixel_x, pixel_y from the lowest bit up, then zero padding.
  output logic [((2*COORD_BITS+4+7)/8)*8-1:0]  m_axis_tdata,
  // last_of_step.
  output logic                                 m_axis_tlast,
  // circle_done.
  output logic                                 m_axis_tuser
);

  localparam int unsigned OctBits = COORD_BITS + 1;
  localparam int unsigned DecBits = COORD_BITS + 4;
  localparam int unsigned PixBits = COORD_BITS + 2;
  localparam int unsigned InBits  = ((3*COORD_BITS+7)/8)*8;
  localparam int unsigned OutBits = ((2*COORD_BITS+4+7)/8)*8;
  localparam int unsigned IdxBits = $clog2(PixPerStep);

  localparam logic signed [DecBits-1:0] DecThree = DecBits'(3);
  localparam logic signed [DecBits-1:0] DecSix   = DecBits'(6);
  localparam logic signed [DecBits-1:0] DecTen   = DecBits'(10);
  localparam logic [IdxBits-1:0]        IdxLast  = IdxBits'(PixPerStep - 1);

  // Circle state.
  logic                        active_q, active_d;
  logic [COORD_BITS-1:0]       cx_q, cx_d, cy_q, cy_d;
  logic signed [OctBits-1:0]   ox_q, ox_d, oy_q, oy_d;
  logic signed [DecBits-1:0]   dec_q, dec_d;

  // Step buffer: the octant point of the step whose pixels are being sent.
  logic                        job_valid_q, job_valid_d;
  logic [COORD_BITS-1:0]       jcx_q, jcy_q;
  logic signed [OctBits-1:0]   jx_q, jy_q;
  logic                        jdone_q;
  logic [IdxBits-1:0]          idx_q, idx_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic signed [PixBits-1:0]   out_px_q, out_py_q;
  logic                        out_last_q, out_done_q;

  logic                        in_accept, out_load, job_free, job_load;
  logic [COORD_BITS-1:0]       in_cx, in_cy, in_r;
  logic signed [DecBits-1:0]   dec_x, dec_y, dec_step;
  logic signed [OctBits-1:0]   next_x, next_y;
  logic                        next_done;
  logic signed [OctBits-1:0]   off_a, off_b;
  logic signed [PixBits-1:0]   pix_cx, pix_cy, pix_a, pix_b, pix_x, pix_y;

  assign in_cx = s_axis_tdata[COORD_BITS-1:0];
  assign in_cy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_r  = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];

  // The output register takes a pixel whenever a step is buffered and the register is empty or being drained.
  assign out_load = job_valid_q && (!out_valid_q || m_axis_tready);
  assign job_free = !job_valid_q || (out_load && (idx_q == IdxLast));

  // Starts and idle steps never need the buffer, but ready does not look at
  // the payload, so every item waits for buffer room.
  assign s_axis_tready = job_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign job_load      = in_accept && (s_axis_tuser == REQ_STEP) && active_q;

  // Decision update. A negative decision keeps y, otherwise y moves inward.
  always_comb begin
    dec_x = {{(DecBits-OctBits){ox_q[OctBits-1]}}, ox_q};
    dec_y = {{(DecBits-OctBits){oy_q[OctBits-1]}}, oy_q};
    if (dec_q[DecBits-1]) begin
      dec_step = dec_q + (dec_x <<< 2) + DecSix;
      next_y   = oy_q;
    end else begin
      dec_step = dec_q + ((dec_x - dec_y) <<< 2) + DecTen;
      next_y   = oy_q - OctBits'(1);
    end
    next_x    = ox_q + OctBits'(1);
    next_done = next_x > next_y;
  end

  always_comb begin
    active_d = active_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    dec_d    = dec_q;
    if (in_accept) begin
      if (s_axis_tuser == REQ_START) begin
        active_d = 1'b1;
        cx_d     = in_cx;
        cy_d     = in_cy;
        ox_d     = '0;
        oy_d     = {1'b0, in_r};
        dec_d    = DecThree - ($signed({{(DecBits-COORD_BITS){1'b0}}, in_r}) <<< 1);
      end else if (active_q) begin
        ox_d     = next_x;
        oy_d     = next_y;
        dec_d    = dec_step;
        active_d = !next_done;
      end
    end
  end

  // Pixel order: the upper index bit swaps x and y, bit 0 negates the column
  // offset and bit 1 negates the row offset.
  always_comb begin
    off_a  = idx_q[2] ? jy_q : jx_q;
    off_b  = idx_q[2] ? jx_q : jy_q;
    pix_cx = $signed({2'b00, jcx_q});
    pix_cy = $signed({2'b00, jcy_q});
    pix_a  = {off_a[OctBits-1], off_a};
    pix_b  = {off_b[OctBits-1], off_b};
    pix_x  = idx_q[0] ? (pix_cx - pix_a) : (pix_cx + pix_a);
    pix_y  = idx_q[1] ? (pix_cy - pix_b) : (pix_cy + pix_b);
  end

  always_comb begin
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    if (out_load) begin
      idx_d = idx_q + IdxBits'(1);
      if (idx_q == IdxLast) begin
        job_valid_d = 1'b0;
      end
    end
    if (job_load) begin
      job_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      dec_q       <= '0;
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
      dec_q       <= dec_d;
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (job_load) begin
      jcx_q   <= cx_q;
      jcy_q   <= cy_q;
      jx_q    <= ox_q;
      jy_q    <= oy_q;
      jdone_q <= next_done;
    end
    if (out_load) begin
      out_px_q   <= pix_x;
      out_py_q   <= pix_y;
      out_last_q <= (idx_q == IdxLast);
      out_done_q <= (idx_q == IdxLast) && jdone_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutBits'({out_py_q, out_px_q});
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

  // The padding bits of the input tdata carry nothing.
  logic unused_pad;
  assign unused_pad = ^{1'b0, s_axis_tdata[InBits-1:0]};

endmodule
